// ===== src/sps_pkg.sv =====
// Shared types, constants and state encoding for the scanline polygon span unit.
`timescale 1ns / 1ps

package sps_pkg;

  // Coordinate width of columns and rows.
  localparam int COORD_W = 16;

  // Default vertex store depth.
  localparam int MAX_VERTICES_DEF = 8;

  // Quotient magnitude bits of the crossing division; one bit is resolved per cycle.
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_EDGE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } sps_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic fetch;
    logic edge_eval;
    logic step;
    logic mul;
    logic div_init;
    logic div_step;
    logic acc;
    logic publish;
  } sps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic store_full;
    logic edge_hit;
    logic last_edge;
    logic div_done;
    logic out_busy;
  } sps_sts_t;

endpackage

// ===== src/sps_ctrl.sv =====
// Controller state machine that sequences loads, edge walks and the crossing division.
`timescale 1ns / 1ps

module sps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_operation,
  input  logic             out_ready,
  input  sps_pkg::sps_sts_t sts,
  output logic             in_ready,
  output sps_pkg::sps_cmd_t cmd
);
  import sps_pkg::*;

  sps_state_t state_r;
  sps_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (sts.count_zero) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = sts.store_full ? ST_DONE : ST_IDLE;
      end
      ST_FETCH: begin
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        if (sts.edge_hit) begin
          state_nxt = ST_MUL;
        end else if (sts.last_edge) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = sts.last_edge ? ST_DONE : ST_FETCH;
      end
      ST_DONE: begin
        if (!sts.out_busy || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EDGE: begin
        cmd.edge_eval = 1'b1;
        cmd.step      = !sts.edge_hit && !sts.last_edge;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_DIV_LOAD: begin
        cmd.div_init = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_ACC: begin
        cmd.acc  = 1'b1;
        cmd.step = !sts.last_edge;
      end
      ST_DONE: begin
        cmd.publish = !sts.out_busy || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The division always runs its full number of steps once started.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !sts.div_done) |=> (state_r == ST_DIV))
    else $error("division left before its last step");

  // A crossing is only computed for an edge that was just found to cover the row.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> ($past(state_r) == ST_EDGE && $past(sts.edge_hit)))
    else $error("multiply entered without a hit edge");

endmodule

// ===== src/sps_datapath.sv =====
// Datapath: vertex store, edge registers, multiplier, divider, span tracking and result register.
`timescale 1ns / 1ps

module sps_datapath #(
  parameter int MAX_VERTICES = sps_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sps_pkg::sps_cmd_t                   cmd,
  output sps_pkg::sps_sts_t                   sts,
  input  logic                                in_operation,
  input  logic                                in_restart,
  input  logic signed [sps_pkg::COORD_W-1:0]  in_vertex_x,
  input  logic signed [sps_pkg::COORD_W-1:0]  in_vertex_y,
  input  logic signed [sps_pkg::COORD_W-1:0]  in_scan_row,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [sps_pkg::COORD_W-1:0]  out_span_left,
  output logic signed [sps_pkg::COORD_W-1:0]  out_span_right,
  output logic                                out_span_found,
  output logic                                out_row_in_range,
  output logic                                out_overflow
);
  import sps_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  // Vertex store.
  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;

  // Polygon bookkeeping.
  logic [CW-1:0]             count_r;
  logic signed [COORD_W-1:0] top_r, bottom_r;

  // Latched item.
  logic                      restart_r;
  logic signed [COORD_W-1:0] vx_r, vy_r, row_r;

  // Edge walk.
  logic [CW-1:0]             idx_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r, x0_r;
  logic signed [COORD_W:0]   dx_r, dyr_r, dy_r;
  logic signed [2*COORD_W+1:0] prod_r;

  // Divider.
  logic [COORD_W-1:0]        rem_r, quo_r, den_r;
  logic                      q_neg_r;
  logic [DCNT_W-1:0]         dcnt_r;

  // Span accumulation.
  logic signed [COORD_W-1:0] left_r, right_r;
  logic                      found_r, in_range_r, ovf_r;

  // Output register.
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_left_r, out_right_r;
  logic                      out_found_r, out_in_range_r, out_ovf_r;

  // Load side.
  logic [CW-1:0] eff_count;
  logic          store_full;
  assign eff_count  = restart_r ? '0 : count_r;
  assign store_full = (eff_count >= MAX_CNT);

  // Edge end point: the wrap edge closes back to the first vertex.
  logic                      last_edge;
  logic signed [COORD_W-1:0] e_x, e_y, lo_y, hi_y;
  logic                      edge_hit;
  logic [AW-1:0]             rd_addr;
  assign last_edge = (idx_r == count_r);
  assign e_x       = last_edge ? first_x_r : rd_x_r;
  assign e_y       = last_edge ? first_y_r : rd_y_r;
  assign lo_y      = (e_y < prev_y_r) ? e_y : prev_y_r;
  assign hi_y      = (e_y < prev_y_r) ? prev_y_r : e_y;
  assign edge_hit  = (idx_r != '0) && (e_y != prev_y_r) && (row_r >= lo_y) && (row_r <= hi_y);
  assign rd_addr   = (idx_r < count_r) ? idx_r[AW-1:0] : '0;

  // Magnitudes for the divider.
  logic [2*COORD_W+1:0] prod_u, prod_abs;
  logic [COORD_W:0]     dy_u, dy_abs;
  assign prod_u   = prod_r;
  assign prod_abs = prod_r[2*COORD_W+1] ? ('0 - prod_u) : prod_u;
  assign dy_u     = dy_r;
  assign dy_abs   = dy_r[COORD_W] ? ('0 - dy_u) : dy_u;

  // One restoring division step.
  logic [COORD_W:0]   shifted;
  logic [COORD_W+1:0] diff;
  logic               ge;
  assign shifted = {rem_r, quo_r[COORD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = !diff[COORD_W+1];

  // Crossing column.
  logic [COORD_W:0]          q_ext, q_sgn, x_sum;
  logic signed [COORD_W-1:0] x_new;
  assign q_ext = {1'b0, quo_r};
  assign q_sgn = q_neg_r ? ('0 - q_ext) : q_ext;
  assign x_sum = {x0_r[COORD_W-1], x0_r} + q_sgn;
  assign x_new = x_sum[COORD_W-1:0];

  always_comb begin
    sts            = '0;
    sts.count_zero = (count_r == '0);
    sts.store_full = store_full;
    sts.edge_hit   = edge_hit;
    sts.last_edge  = last_edge;
    sts.div_done   = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
    sts.out_busy   = out_valid_r;
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      mem_x[eff_count[AW-1:0]] <= vx_r;
      mem_y[eff_count[AW-1:0]] <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      top_r       <= '0;
      bottom_r    <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && !store_full) begin
        count_r <= eff_count + CW'(1);
        if (eff_count == '0) begin
          top_r    <= vy_r;
          bottom_r <= vy_r;
        end else begin
          if (vy_r < top_r) begin
            top_r <= vy_r;
          end
          if (vy_r > bottom_r) begin
            bottom_r <= vy_r;
          end
        end
      end
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.step) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      restart_r  <= in_restart;
      vx_r       <= in_vertex_x;
      vy_r       <= in_vertex_y;
      row_r      <= in_scan_row;
      left_r     <= '0;
      right_r    <= '0;
      found_r    <= 1'b0;
      ovf_r      <= 1'b0;
      in_range_r <= (in_operation == OP_QUERY) && (count_r != '0) &&
                    (in_scan_row >= top_r) && (in_scan_row <= bottom_r);
    end
    if (cmd.load && store_full) begin
      ovf_r <= 1'b1;
    end
    if (cmd.edge_eval) begin
      if (idx_r == '0) begin
        first_x_r <= rd_x_r;
        first_y_r <= rd_y_r;
      end
      prev_x_r <= e_x;
      prev_y_r <= e_y;
      x0_r     <= prev_x_r;
      dx_r     <= {e_x[COORD_W-1], e_x} - {prev_x_r[COORD_W-1], prev_x_r};
      dyr_r    <= {row_r[COORD_W-1], row_r} - {prev_y_r[COORD_W-1], prev_y_r};
      dy_r     <= {e_y[COORD_W-1], e_y} - {prev_y_r[COORD_W-1], prev_y_r};
    end
    if (cmd.mul) begin
      prod_r <= dx_r * dyr_r;
    end
    if (cmd.div_init) begin
      // The quotient magnitude never exceeds the column difference, so the upper
      // half of the numerator is already below the divisor.
      rem_r   <= prod_abs[2*COORD_W-1:COORD_W];
      quo_r   <= prod_abs[COORD_W-1:0];
      den_r   <= dy_abs[COORD_W-1:0];
      q_neg_r <= prod_r[2*COORD_W+1] ^ dy_r[COORD_W];
      dcnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
      quo_r  <= {quo_r[COORD_W-2:0], ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.acc) begin
      found_r <= 1'b1;
      if (!found_r || (x_new < left_r)) begin
        left_r <= x_new;
      end
      if (!found_r || (x_new > right_r)) begin
        right_r <= x_new;
      end
    end
    if (cmd.publish) begin
      out_left_r     <= left_r;
      out_right_r    <= right_r;
      out_found_r    <= found_r;
      out_in_range_r <= in_range_r;
      out_ovf_r      <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_span_left    = out_left_r;
  assign out_span_right   = out_right_r;
  assign out_span_found   = out_found_r;
  assign out_row_in_range = out_in_range_r;
  assign out_overflow     = out_ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("vertex count above store depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_left_r <= out_right_r))
    else $error("span left beyond span right");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (!out_found_r && !out_in_range_r))
    else $error("overflow result carries span data");

endmodule

// ===== src/scanline_polygon_span.sv =====
// Top level of the scanline polygon span unit: controller plus datapath.
`timescale 1ns / 1ps

// This block holds a closed polygon of up to MAX_VERTICES signed 16-bit
// vertices and answers row queries with the leftmost and rightmost edge
// crossing on that row. A load item (operation 0) stores one vertex, with
// restart emptying the list first; it gives no result, unless the store is
// full, in which case the vertex is dropped and a result with overflow set
// follows. A query item (operation 1) walks the stored edges one at a time,
// closing from the last vertex back to the first, through a single-ported
// vertex memory with registered read data. Each edge is fetched and tested;
// for an edge that covers the row the unit then multiplies, sets up the
// bit-serial restoring divider, runs it to produce the crossing (truncated
// toward zero) and folds the crossing into the span. The divider dominates
// the time of a query in which edges cover the row. Items are handled one
// at a time; the finished result sits in an output register, so a new item
// is accepted while the previous result still waits to be taken. An empty
// store gives a result of all zeros.
module scanline_polygon_span #(
  parameter int MAX_VERTICES = sps_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic                               in_restart,
  input  logic signed [sps_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [sps_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [sps_pkg::COORD_W-1:0] in_scan_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sps_pkg::COORD_W-1:0] out_span_left,
  output logic signed [sps_pkg::COORD_W-1:0] out_span_right,
  output logic                               out_span_found,
  output logic                               out_row_in_range,
  output logic                               out_overflow
);
  import sps_pkg::*;

  sps_cmd_t cmd;
  sps_sts_t sts;

  // The controller sequences the item; it sees the datapath only through
  // the command and status structs.
  sps_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_ready    (out_ready),
    .sts          (sts),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  // The datapath owns the vertex memory, the arithmetic and the result register.
  sps_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_restart       (in_restart),
    .in_vertex_x      (in_vertex_x),
    .in_vertex_y      (in_vertex_y),
    .in_scan_row      (in_scan_row),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_span_left    (out_span_left),
    .out_span_right   (out_span_right),
    .out_span_found   (out_span_found),
    .out_row_in_range (out_row_in_range),
    .out_overflow     (out_overflow)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the scanline polygon span unit.
`timescale 1ns / 1ps

typedef logic signed [sps_pkg::COORD_W-1:0] coord_t;

// One input item as it crosses the input handshake.
typedef struct packed {
  logic   operation;
  logic   restart;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t scan_row;
} polygon_item_t;

// One result item as it crosses the output handshake.
typedef struct packed {
  coord_t span_left;
  coord_t span_right;
  logic   span_found;
  logic   row_in_range;
  logic   overflow;
} span_result_t;

// Keeps a private copy of the polygon and the spans still owed by the block.
class span_scoreboard;
  coord_t       vertex_cols [sps_pkg::MAX_VERTICES_DEF];
  coord_t       vertex_rows [sps_pkg::MAX_VERTICES_DEF];
  int unsigned  vertex_count;
  coord_t       top_row;
  coord_t       bottom_row;
  span_result_t pending_spans [$];
  int unsigned  error_count;

  function new();
    vertex_count = 0;
    top_row      = '0;
    bottom_row   = '0;
    error_count  = 0;
  endfunction

  // Walks every closed edge and folds its crossing with the row into a span.
  function span_result_t trace_row_span(coord_t row);
    span_result_t span;
    longint       row_l, ya, yb, xa, xb, crossing;
    int unsigned  nxt;
    span = '0;
    row_l = row;
    span.row_in_range = (vertex_count > 0) && (row >= top_row) && (row <= bottom_row);
    for (int unsigned i = 0; i < vertex_count; i++) begin
      nxt = (i + 1 < vertex_count) ? i + 1 : 0;
      ya = vertex_rows[i];
      yb = vertex_rows[nxt];
      xa = vertex_cols[i];
      xb = vertex_cols[nxt];
      if (ya == yb) continue;
      if (row_l < ((ya < yb) ? ya : yb) || row_l > ((ya > yb) ? ya : yb)) continue;
      // Signed division in SystemVerilog truncates toward zero.
      crossing = xa + ((xb - xa) * (row_l - ya)) / (yb - ya);
      if (!span.span_found) begin
        span.span_left  = coord_t'(crossing);
        span.span_right = coord_t'(crossing);
        span.span_found = 1'b1;
      end else begin
        if (coord_t'(crossing) < span.span_left)  span.span_left  = coord_t'(crossing);
        if (coord_t'(crossing) > span.span_right) span.span_right = coord_t'(crossing);
      end
    end
    return span;
  endfunction

  function void note_item(polygon_item_t item);
    span_result_t dropped;
    if (item.operation == sps_pkg::OP_LOAD) begin
      if (item.restart) vertex_count = 0;
      if (vertex_count >= sps_pkg::MAX_VERTICES_DEF) begin
        dropped = '0;
        dropped.overflow = 1'b1;
        pending_spans.push_back(dropped);
        return;
      end
      vertex_cols[vertex_count] = item.vertex_x;
      vertex_rows[vertex_count] = item.vertex_y;
      if (vertex_count == 0) begin
        top_row    = item.vertex_y;
        bottom_row = item.vertex_y;
      end else begin
        if (item.vertex_y < top_row)    top_row    = item.vertex_y;
        if (item.vertex_y > bottom_row) bottom_row = item.vertex_y;
      end
      vertex_count++;
    end else begin
      pending_spans.push_back(trace_row_span(item.scan_row));
    end
  endfunction

  function void check_result(span_result_t got);
    span_result_t want;
    if (pending_spans.size() == 0) begin
      $error("result item with no span pending: left %0d right %0d overflow %0b",
             got.span_left, got.span_right, got.overflow);
      error_count++;
      return;
    end
    want = pending_spans.pop_front();
    if (got.span_left !== want.span_left) begin
      $error("span_left: expected %0d, got %0d", want.span_left, got.span_left);
      error_count++;
    end
    if (got.span_right !== want.span_right) begin
      $error("span_right: expected %0d, got %0d", want.span_right, got.span_right);
      error_count++;
    end
    if (got.span_found !== want.span_found) begin
      $error("span_found: expected %0b, got %0b", want.span_found, got.span_found);
      error_count++;
    end
    if (got.row_in_range !== want.row_in_range) begin
      $error("row_in_range: expected %0b, got %0b", want.row_in_range, got.row_in_range);
      error_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      error_count++;
    end
  endfunction
endclass

module testbench;

  // The watchdog limit leaves a wide margin above the slowest query, one over
  // a full store with every edge covering the row, plus random stalls on either
  // side.
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1800;
  localparam int SETTLE_CYCLES = 200;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  logic   in_operation = sps_pkg::OP_LOAD;
  logic   in_restart = 1'b0;
  coord_t in_vertex_x = '0;
  coord_t in_vertex_y = '0;
  coord_t in_scan_row = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t out_span_left;
  coord_t out_span_right;
  logic   out_span_found;
  logic   out_row_in_range;
  logic   out_overflow;

  // Percentage of cycles in which each side idles; dropped to zero for a stretch.
  int          idle_pct = 23;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  span_scoreboard spans = new();

  scanline_polygon_span u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_restart       (in_restart),
    .in_vertex_x      (in_vertex_x),
    .in_vertex_y      (in_vertex_y),
    .in_scan_row      (in_scan_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span_left    (out_span_left),
    .out_span_right   (out_span_right),
    .out_span_found   (out_span_found),
    .out_row_in_range (out_row_in_range),
    .out_overflow     (out_overflow)
  );

  always #4 clk = ~clk;

  // The receiver decides at each falling edge whether it takes a result next cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Both handshakes are observed at the rising edge, where every testbench-driven
  // signal has been stable since the falling edge. Accepted inputs feed the
  // predictor, and accepted results are checked against the oldest prediction.
  always @(posedge clk) begin : handshake_monitor
    polygon_item_t accepted;
    span_result_t  observed;
    if (rst_n && in_valid && in_ready) begin
      accepted.operation = in_operation;
      accepted.restart   = in_restart;
      accepted.vertex_x  = in_vertex_x;
      accepted.vertex_y  = in_vertex_y;
      accepted.scan_row  = in_scan_row;
      spans.note_item(accepted);
    end
    if (rst_n && out_valid && out_ready) begin
      observed.span_left    = out_span_left;
      observed.span_right   = out_span_right;
      observed.span_found   = out_span_found;
      observed.row_in_range = out_row_in_range;
      observed.overflow     = out_overflow;
      spans.check_result(observed);
    end
  end

  // A run in which neither handshake completes for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL scanline_polygon_span");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one item, with random idle cycles ahead of it, and returns at the
  // falling edge after it was taken. It is always entered at a falling edge.
  task automatic send_item(input logic op, input logic restart, input coord_t vx,
                           input coord_t vy, input coord_t row);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_restart   <= restart;
    in_vertex_x  <= vx;
    in_vertex_y  <= vy;
    in_scan_row  <= row;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // The unused fields of each item carry random bits so that every input bit toggles.
  task automatic load_vertex(input logic restart, input coord_t vx, input coord_t vy);
    send_item(sps_pkg::OP_LOAD, restart, vx, vy, coord_t'($urandom));
  endtask

  task automatic query_row(input coord_t row);
    send_item(sps_pkg::OP_QUERY, 1'($urandom), coord_t'($urandom), coord_t'($urandom), row);
  endtask

  // Holds the sender back until every owed result has come out. The item just
  // taken is withdrawn first so that it is not presented a second time.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (spans.pending_spans.size() != 0);
  endtask

  // Small polygons exercise the arithmetic near zero; wide ones reach the extremes.
  function automatic coord_t random_coord(input bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(200)) - 100);
  endfunction

  // Most queries land near or inside the polygon's row extent, some exactly on
  // a vertex row, and the rest anywhere.
  function automatic coord_t pick_query_row();
    int unsigned pick;
    int          lo, hi;
    pick = $urandom_range(99);
    if (pick < 60) begin
      lo = int'(spans.top_row) - 3;
      hi = int'(spans.bottom_row) + 3;
      return coord_t'(lo + int'($urandom_range(unsigned'(hi - lo))));
    end
    if (pick < 80 && spans.vertex_count > 0)
      return spans.vertex_rows[$urandom_range(spans.vertex_count - 1)];
    return coord_t'($urandom);
  endfunction

  initial begin
    int unsigned corners, queries, pick;
    bit          wide;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A query on an empty store gives all zeros.
    query_row(16'sd0);

    // A lone vertex makes only a horizontal edge: in range on its row, no span.
    load_vertex(1'b1, 16'sd5, -16'sd7);
    query_row(-16'sd7);
    query_row(-16'sd6);

    // A triangle at the coordinate extremes, queried at its top, middle, bottom
    // and at rows where the crossing quotient is negative and gets truncated.
    load_vertex(1'b1, -16'sd32768, -16'sd32768);
    load_vertex(1'b0, 16'sd32767, 16'sd0);
    load_vertex(1'b0, -16'sd32768, 16'sd32767);
    query_row(-16'sd32768);
    query_row(16'sd0);
    query_row(16'sd32767);
    query_row(-16'sd1);
    query_row(16'sd12345);

    // A square whose top and bottom edges are horizontal, plus a row below it.
    load_vertex(1'b1, 16'sd0, 16'sd0);
    load_vertex(1'b0, 16'sd10, 16'sd0);
    load_vertex(1'b0, 16'sd10, 16'sd10);
    load_vertex(1'b0, 16'sd0, 16'sd10);
    query_row(16'sd0);
    query_row(16'sd5);
    query_row(16'sd11);

    // Fill the store, then push two loads into a full store and recover with a restart.
    for (int k = 0; k < 6; k++) load_vertex(1'b0, coord_t'(k * 3 - 7), coord_t'(20 - k * 9));
    load_vertex(1'b1, 16'sd3, 16'sd3);
    query_row(16'sd3);

    // The sender waits here once for every owed result before going on.
    drain_results();

    // Random part: mostly complete polygons followed by queries on them, with
    // some overfull loads and some loose items mixed in.
    while (items_sent < ITEM_TARGET) begin
      idle_pct = (items_sent >= 600 && items_sent < 900) ? 0 : 23;
      pick = $urandom_range(99);
      if (pick < 80) begin
        pick = $urandom_range(99);
        if (pick < 10)      corners = $urandom_range(11, 9);
        else if (pick < 20) corners = $urandom_range(2, 1);
        else                corners = $urandom_range(8, 3);
        wide = 1'($urandom);
        load_vertex(1'b1, random_coord(wide), random_coord(wide));
        for (int unsigned c = 1; c < corners; c++)
          load_vertex(1'b0, random_coord(wide), random_coord(wide));
        queries = $urandom_range(6, 1);
        for (int unsigned q = 0; q < queries; q++) query_row(pick_query_row());
      end else begin
        send_item(1'($urandom), 1'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
      end
      if ($urandom_range(19) == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (spans.error_count == 0 && spans.pending_spans.size() == 0) begin
      $display("PASS scanline_polygon_span");
    end else begin
      $display("FAIL scanline_polygon_span");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sps_pkg.sv
src/sps_ctrl.sv
src/sps_datapath.sv
src/scanline_polygon_span.sv
verif/testbench.sv
